// ===== rtl/bpc_pkg.sv =====
// Shared types and constants for the barometric poll and compensation block.
// Holds the microcode word layout, the compensation program and the port layouts.
// Depends on nothing.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int IN_W  = 56;
    localparam int OUT_W = 56;
    localparam int ACC_W = 62;

    localparam logic [31:0] CONV_WAIT_MS     = 32'd9;
    localparam logic [15:0] TEMP_PERIOD_RST  = 16'd1000;
    localparam logic [15:0] PRESS_PERIOD_RST = 16'd20;

    typedef logic signed [ACC_W-1:0] acc_t;

    localparam acc_t TEMP_BASE = 62'sd16777216000;
    localparam acc_t P_MAX     = 62'sd2147483647;
    localparam acc_t P_MIN     = -62'sd2147483648;

    typedef enum logic [1:0] {
        ACT_NONE        = 2'd0,
        ACT_START_TEMP  = 2'd1,
        ACT_START_PRESS = 2'd2,
        ACT_READ        = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_SENS      = 3'd0,
        REG_OFF       = 3'd1,
        REG_SENS_TC   = 3'd2,
        REG_OFF_TC    = 3'd3,
        REG_TREF      = 3'd4,
        REG_TSENS     = 3'd5,
        REG_T_PERIOD  = 3'd6,
        REG_P_PERIOD  = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [15:0] sens;
        logic [15:0] off;
        logic [15:0] sens_tc;
        logic [15:0] off_tc;
        logic [15:0] tref;
        logic [15:0] tsens;
    } coeff_t;

    typedef struct packed {
        logic               done;
        logic signed [18:0] temperature;
        logic signed [31:0] pressure;
    } comp_result_t;

    typedef enum logic [1:0] {
        SEQ_WAIT,
        SEQ_NEXT,
        SEQ_END
    } seq_t;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_DT,
        ALU_BASE,
        ALU_ADD_HI,
        ALU_TRUNC,
        ALU_FINISH
    } alu_op_t;

    typedef enum logic [1:0] {
        BASE_TEMP,
        BASE_OFF,
        BASE_SENS,
        BASE_PRESS
    } base_sel_t;

    typedef enum logic [1:0] {
        SH_23,
        SH_6,
        SH_7,
        SH_36
    } shift_sel_t;

    typedef enum logic [1:0] {
        DST_NONE,
        DST_TEMP,
        DST_OFF,
        DST_SENS
    } dst_t;

    typedef enum logic {
        MA_DT,
        MA_D1
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_C6,
        MB_C4,
        MB_C3,
        MB_SLO,
        MB_SHI
    } mul_b_t;

    typedef struct packed {
        seq_t       seq;
        alu_op_t    alu;
        base_sel_t  base;
        shift_sel_t shift;
        dst_t       dst;
        logic       mul_en;
        mul_a_t     mul_a;
        mul_b_t     mul_b;
    } ucode_t;

    // Compensation program: dT, TEMP, OFF, SENS, then P in two partial products.
    function automatic ucode_t ucode(input logic [3:0] step);
        ucode_t w;
        w = '{SEQ_WAIT, ALU_NOP, BASE_TEMP, SH_23, DST_NONE, 1'b0, MA_DT, MB_C6};
        unique case (step)
            4'd0:  w = '{SEQ_WAIT, ALU_NOP,    BASE_TEMP,  SH_23, DST_NONE, 1'b0, MA_DT, MB_C6};
            4'd1:  w = '{SEQ_NEXT, ALU_DT,     BASE_TEMP,  SH_23, DST_NONE, 1'b0, MA_DT, MB_C6};
            4'd2:  w = '{SEQ_NEXT, ALU_NOP,    BASE_TEMP,  SH_23, DST_NONE, 1'b1, MA_DT, MB_C6};
            4'd3:  w = '{SEQ_NEXT, ALU_BASE,   BASE_TEMP,  SH_23, DST_NONE, 1'b0, MA_DT, MB_C6};
            4'd4:  w = '{SEQ_NEXT, ALU_TRUNC,  BASE_TEMP,  SH_23, DST_TEMP, 1'b1, MA_DT, MB_C4};
            4'd5:  w = '{SEQ_NEXT, ALU_BASE,   BASE_OFF,   SH_23, DST_NONE, 1'b1, MA_DT, MB_C3};
            4'd6:  w = '{SEQ_NEXT, ALU_TRUNC,  BASE_OFF,   SH_6,  DST_OFF,  1'b0, MA_DT, MB_C3};
            4'd7:  w = '{SEQ_NEXT, ALU_BASE,   BASE_SENS,  SH_7,  DST_NONE, 1'b0, MA_DT, MB_C3};
            4'd8:  w = '{SEQ_NEXT, ALU_TRUNC,  BASE_SENS,  SH_7,  DST_SENS, 1'b0, MA_DT, MB_C3};
            4'd9:  w = '{SEQ_NEXT, ALU_NOP,    BASE_PRESS, SH_36, DST_NONE, 1'b1, MA_D1, MB_SLO};
            4'd10: w = '{SEQ_NEXT, ALU_BASE,   BASE_PRESS, SH_36, DST_NONE, 1'b1, MA_D1, MB_SHI};
            4'd11: w = '{SEQ_NEXT, ALU_ADD_HI, BASE_PRESS, SH_36, DST_NONE, 1'b0, MA_D1, MB_SHI};
            4'd12: w = '{SEQ_NEXT, ALU_TRUNC,  BASE_PRESS, SH_36, DST_NONE, 1'b0, MA_D1, MB_SHI};
            4'd13: w = '{SEQ_END,  ALU_FINISH, BASE_PRESS, SH_36, DST_NONE, 1'b0, MA_D1, MB_SHI};
            default: w = '{SEQ_WAIT, ALU_NOP, BASE_TEMP, SH_23, DST_NONE, 1'b0, MA_DT, MB_C6};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/baro_poll_and_compensate.sv =====
// Top level: poll decision, sensor state, configuration registers and output register.
// Depends on bpc_pkg and bpc_comp.
`timescale 1ns / 1ps

// One poll is handled at a time. A poll that starts a conversion or does nothing
// goes from the transfer to the emit state, which writes its result into the output
// register. A poll that reads the sensor first runs the 13-step compensation
// program through the single 25x19 multiplier and 62-bit accumulator, and its
// result then goes through the emit state in the same way. The next poll is taken
// as soon as the result sits in the output register, even if it has not yet
// been taken; a result still waiting there holds the following one and stalls
// the input.
module baro_poll_and_compensate
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [bpc_pkg::IN_W-1:0] s_tdata,   // now_ms[31:0], adc_word[55:32]
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [bpc_pkg::OUT_W-1:0] m_tdata,  // action[1:0], temperature_centi[20:2],
                                                // pressure_pa[52:21], new_data[53], zero[55:54]
    input  logic                     wr_en,
    input  logic [2:0]               wr_index,
    input  logic [15:0]              wr_data
);

    bpc_pkg::state_t        state_reg;
    bpc_pkg::state_t        state_next;
    bpc_pkg::coeff_t        coeff_reg;
    logic [15:0]            t_period_reg;
    logic [15:0]            p_period_reg;

    logic                   pending_reg;
    logic                   pending_next;
    logic                   pend_press_reg;
    logic                   pend_press_next;
    logic [31:0]            last_temp_reg;
    logic [31:0]            last_temp_next;
    logic [31:0]            last_press_reg;
    logic [31:0]            last_press_next;
    logic [31:0]            last_cmd_reg;
    logic [31:0]            last_cmd_next;
    logic [23:0]            raw_temp_reg;
    logic [23:0]            raw_temp_next;
    logic [23:0]            raw_press_reg;
    logic [23:0]            raw_press_next;
    logic signed [18:0]     rep_temp_reg;
    logic signed [18:0]     rep_temp_next;
    logic signed [31:0]     rep_press_reg;
    logic signed [31:0]     rep_press_next;
    logic                   new_data_reg;
    logic                   new_data_next;
    bpc_pkg::action_t       action_reg;
    bpc_pkg::action_t       action_next;
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [bpc_pkg::OUT_W-1:0] m_tdata_reg;
    logic [bpc_pkg::OUT_W-1:0] m_tdata_next;

    logic                   accept;
    logic [31:0]            now_ms;
    logic [23:0]            adc_word;
    logic                   temp_due;
    logic                   press_due;
    logic                   read_due;
    logic                   go;
    bpc_pkg::comp_result_t  res;

    assign s_tready = (state_reg == bpc_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign now_ms   = s_tdata[31:0];
    assign adc_word = s_tdata[55:32];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign temp_due  = !pending_reg && ((now_ms - last_temp_reg) > {16'b0, t_period_reg});
    assign press_due = !pending_reg && ((now_ms - last_press_reg) > {16'b0, p_period_reg});
    assign read_due  = pending_reg && ((now_ms - last_cmd_reg) > bpc_pkg::CONV_WAIT_MS);
    assign go        = accept && !temp_due && !press_due && read_due;

    bpc_comp u_comp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .raw_temp  (raw_temp_reg),
        .raw_press (raw_press_reg),
        .coeff     (coeff_reg),
        .res       (res)
    );

    always_comb
    begin
        state_next      = state_reg;
        pending_next    = pending_reg;
        pend_press_next = pend_press_reg;
        last_temp_next  = last_temp_reg;
        last_press_next = last_press_reg;
        last_cmd_next   = last_cmd_reg;
        raw_temp_next   = raw_temp_reg;
        raw_press_next  = raw_press_reg;
        rep_temp_next   = rep_temp_reg;
        rep_press_next  = rep_press_reg;
        new_data_next   = new_data_reg;
        action_next     = action_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        unique case (state_reg)
            bpc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = bpc_pkg::ST_EMIT;
                    action_next = bpc_pkg::ACT_NONE;
                    priority if (temp_due)
                    begin
                        pending_next    = 1'b1;
                        pend_press_next = 1'b0;
                        new_data_next   = 1'b0;
                        last_cmd_next   = now_ms;
                        action_next     = bpc_pkg::ACT_START_TEMP;
                    end
                    else if (press_due)
                    begin
                        pending_next    = 1'b1;
                        pend_press_next = 1'b1;
                        new_data_next   = 1'b0;
                        last_cmd_next   = now_ms;
                        action_next     = bpc_pkg::ACT_START_PRESS;
                    end
                    else if (read_due)
                    begin
                        if (pend_press_reg)
                        begin
                            raw_press_next  = adc_word;
                            last_press_next = now_ms;
                        end
                        else
                        begin
                            raw_temp_next  = adc_word;
                            last_temp_next = now_ms;
                        end
                        pending_next = 1'b0;
                        action_next  = bpc_pkg::ACT_READ;
                        state_next   = bpc_pkg::ST_COMP;
                    end
                    else
                    begin
                        action_next = bpc_pkg::ACT_NONE;
                    end
                end
            end
            bpc_pkg::ST_COMP:
            begin
                if (res.done)
                begin
                    state_next = bpc_pkg::ST_EMIT;
                    if (res.temperature != rep_temp_reg || res.pressure != rep_press_reg)
                    begin
                        rep_temp_next  = res.temperature;
                        rep_press_next = res.pressure;
                        new_data_next  = 1'b1;
                    end
                    else
                    begin
                        new_data_next = 1'b0;
                    end
                end
            end
            bpc_pkg::ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, new_data_reg, rep_press_reg, rep_temp_reg,
                                     action_reg};
                    state_next    = bpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg    <= '0;
            t_period_reg <= bpc_pkg::TEMP_PERIOD_RST;
            p_period_reg <= bpc_pkg::PRESS_PERIOD_RST;
        end
        else if (wr_en)
        begin
            unique case (bpc_pkg::cfg_reg_t'(wr_index))
                bpc_pkg::REG_SENS:     coeff_reg.sens    <= wr_data;
                bpc_pkg::REG_OFF:      coeff_reg.off     <= wr_data;
                bpc_pkg::REG_SENS_TC:  coeff_reg.sens_tc <= wr_data;
                bpc_pkg::REG_OFF_TC:   coeff_reg.off_tc  <= wr_data;
                bpc_pkg::REG_TREF:     coeff_reg.tref    <= wr_data;
                bpc_pkg::REG_TSENS:    coeff_reg.tsens   <= wr_data;
                bpc_pkg::REG_T_PERIOD: t_period_reg      <= wr_data;
                bpc_pkg::REG_P_PERIOD: p_period_reg      <= wr_data;
                default:               t_period_reg      <= t_period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bpc_pkg::ST_IDLE;
            pending_reg    <= 1'b0;
            pend_press_reg <= 1'b0;
            last_temp_reg  <= '0;
            last_press_reg <= '0;
            last_cmd_reg   <= '0;
            raw_temp_reg   <= '0;
            raw_press_reg  <= '0;
            rep_temp_reg   <= '0;
            rep_press_reg  <= '0;
            new_data_reg   <= 1'b0;
            action_reg     <= bpc_pkg::ACT_NONE;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pending_reg    <= pending_next;
            pend_press_reg <= pend_press_next;
            last_temp_reg  <= last_temp_next;
            last_press_reg <= last_press_next;
            last_cmd_reg   <= last_cmd_next;
            raw_temp_reg   <= raw_temp_next;
            raw_press_reg  <= raw_press_next;
            rep_temp_reg   <= rep_temp_next;
            rep_press_reg  <= rep_press_next;
            new_data_reg   <= new_data_next;
            action_reg     <= action_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> state_reg == bpc_pkg::ST_COMP)
        else $error("compensation finished outside a read");

    a_read_starts_comp: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> state_reg == bpc_pkg::ST_COMP)
        else $error("read transfer did not start compensation");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == bpc_pkg::ST_EMIT))
        else $error("result shown without passing through emit");

    a_flag_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(new_data_reg) |-> $past(res.done))
        else $error("new-data flag set without a finished compensation");

endmodule

// ===== rtl/bpc_comp.sv =====
// Microcoded compensation engine: step counter, program table, one multiplier, one accumulator.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_comp
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic [23:0]           raw_temp,
    input  logic [23:0]           raw_press,
    input  bpc_pkg::coeff_t       coeff,
    output bpc_pkg::comp_result_t res
);

    logic [3:0]            step_reg;
    logic [3:0]            step_next;
    bpc_pkg::ucode_t       uw;

    logic signed [24:0]    dt_reg;
    logic signed [24:0]    dt_next;
    logic signed [43:0]    prod_reg;
    logic signed [43:0]    prod_next;
    bpc_pkg::acc_t         acc_reg;
    bpc_pkg::acc_t         acc_next;
    logic signed [18:0]    temp_reg;
    logic signed [18:0]    temp_next;
    logic signed [35:0]    off_reg;
    logic signed [35:0]    off_next;
    logic signed [35:0]    sens_reg;
    logic signed [35:0]    sens_next;

    logic signed [24:0]    mul_a;
    logic signed [18:0]    mul_b;
    bpc_pkg::acc_t         base;
    bpc_pkg::acc_t         prod_ext;
    bpc_pkg::acc_t         bias;
    bpc_pkg::acc_t         tsum;
    bpc_pkg::acc_t         tval;
    logic [5:0]            shamt;
    logic signed [31:0]    press_sat;

    assign uw = bpc_pkg::ucode(step_reg);

    always_comb
    begin
        unique case (uw.seq)
            bpc_pkg::SEQ_WAIT: step_next = go ? step_reg + 4'd1 : step_reg;
            bpc_pkg::SEQ_NEXT: step_next = step_reg + 4'd1;
            bpc_pkg::SEQ_END:  step_next = 4'd0;
            default:           step_next = 4'd0;
        endcase
    end

    always_comb
    begin
        unique case (uw.mul_a)
            bpc_pkg::MA_DT: mul_a = dt_reg;
            bpc_pkg::MA_D1: mul_a = $signed({1'b0, raw_press});
            default:        mul_a = dt_reg;
        endcase
        unique case (uw.mul_b)
            bpc_pkg::MB_C6:  mul_b = $signed({3'b000, coeff.tsens});
            bpc_pkg::MB_C4:  mul_b = $signed({3'b000, coeff.off_tc});
            bpc_pkg::MB_C3:  mul_b = $signed({3'b000, coeff.sens_tc});
            bpc_pkg::MB_SLO: mul_b = $signed({1'b0, sens_reg[17:0]});
            bpc_pkg::MB_SHI: mul_b = $signed({sens_reg[35], sens_reg[35:18]});
            default:         mul_b = '0;
        endcase
        prod_next = uw.mul_en ? mul_a * mul_b : prod_reg;
    end

    always_comb
    begin
        unique case (uw.base)
            bpc_pkg::BASE_TEMP:  base = bpc_pkg::TEMP_BASE;
            bpc_pkg::BASE_OFF:   base = bpc_pkg::acc_t'({coeff.off, 23'b0});
            bpc_pkg::BASE_SENS:  base = bpc_pkg::acc_t'({coeff.sens, 23'b0});
            bpc_pkg::BASE_PRESS: base = -(bpc_pkg::acc_t'(off_reg) <<< 21);
            default:             base = '0;
        endcase
        unique case (uw.shift)
            bpc_pkg::SH_23: shamt = 6'd23;
            bpc_pkg::SH_6:  shamt = 6'd6;
            bpc_pkg::SH_7:  shamt = 6'd7;
            bpc_pkg::SH_36: shamt = 6'd36;
            default:        shamt = 6'd0;
        endcase
        prod_ext = bpc_pkg::acc_t'(prod_reg);
        // truncate toward zero: bias negative values before the arithmetic shift
        bias = acc_reg[bpc_pkg::ACC_W-1]
             ? (bpc_pkg::acc_t'(1) <<< shamt) - bpc_pkg::acc_t'(1) : '0;
        tsum = acc_reg + bias;
        tval = tsum >>> shamt;
        if (acc_reg > bpc_pkg::P_MAX)
        begin
            press_sat = 32'sh7fffffff;
        end
        else if (acc_reg < bpc_pkg::P_MIN)
        begin
            press_sat = -32'sh80000000;
        end
        else
        begin
            press_sat = acc_reg[31:0];
        end
    end

    always_comb
    begin
        dt_next   = dt_reg;
        acc_next  = acc_reg;
        temp_next = temp_reg;
        off_next  = off_reg;
        sens_next = sens_reg;
        unique case (uw.alu)
            bpc_pkg::ALU_NOP:    acc_next = acc_reg;
            bpc_pkg::ALU_DT:     dt_next = $signed({1'b0, raw_temp})
                                         - $signed({1'b0, coeff.tref, 8'b0});
            bpc_pkg::ALU_BASE:   acc_next = base + prod_ext;
            bpc_pkg::ALU_ADD_HI: acc_next = acc_reg + (prod_ext <<< 18);
            bpc_pkg::ALU_TRUNC:
            begin
                acc_next = tval;
                unique case (uw.dst)
                    bpc_pkg::DST_NONE: acc_next = tval;
                    bpc_pkg::DST_TEMP: temp_next = tval[18:0];
                    bpc_pkg::DST_OFF:  off_next = tval[35:0];
                    bpc_pkg::DST_SENS: sens_next = tval[35:0];
                    default:           acc_next = tval;
                endcase
            end
            bpc_pkg::ALU_FINISH: acc_next = acc_reg;
            default:             acc_next = acc_reg;
        endcase
    end

    assign res.done        = (uw.alu == bpc_pkg::ALU_FINISH);
    assign res.temperature = temp_reg;
    assign res.pressure    = press_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 4'd0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg   <= dt_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        temp_reg <= temp_next;
        off_reg  <= off_next;
        sens_reg <= sens_next;
    end

endmodule
